// ===== hw/rtl/jis_pkg.sv =====
`default_nettype none

package jis_pkg;

    localparam int NUM_W = 64;

    localparam logic [1:0] KIND_MATRIX = 2'd0;
    localparam logic [1:0] KIND_RHS    = 2'd1;
    localparam logic [1:0] KIND_SOLVE  = 2'd2;

    localparam logic [1:0] CFG_ORDER = 2'd0;
    localparam logic [1:0] CFG_TOL   = 2'd1;
    localparam logic [1:0] CFG_MAXIT = 2'd2;

    localparam logic [1:0] STATUS_CONV  = 2'd0;
    localparam logic [1:0] STATUS_LIMIT = 2'd1;
    localparam logic [1:0] STATUS_ZERO  = 2'd2;

    localparam logic [5:0]  CFG_ORDER_RST = 6'd4;
    localparam logic [15:0] CFG_TOL_RST   = 16'd98;
    localparam logic [15:0] CFG_MAXIT_RST = 16'd1000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [15:0] value;
    } t_in_req;

    typedef struct packed {
        logic [4:0]         index;
        logic signed [31:0] solution;
        logic               last;
        logic [1:0]         status;
        logic [15:0]        iterations;
    } t_out_req;

    typedef struct packed {
        logic                     start;
        logic signed [NUM_W-1:0]  num;
        logic signed [15:0]       den;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [31:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIAG,
        ST_DIAG_END,
        ST_INIT_RD,
        ST_INIT_DIV,
        ST_INIT_WAIT,
        ST_SWEEP_CHK,
        ST_ROW_INIT,
        ST_ROW_WALK,
        ST_ROW_DRAIN,
        ST_ROW_DIV,
        ST_ROW_WAIT,
        ST_SWEEP_END,
        ST_SWEEP_TEST,
        ST_OUT_RD,
        ST_OUT_LD
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/jacobi_iterative_solver_core.sv =====
// channel | dir | handshake               | payload
// in      | in  | i_in_valid / o_in_stall  | i_in  (kind, row, col, value)
// out     | out | o_out_valid / i_out_stall| o_out (index, solution, last, status, iterations)
// cfg     | in  | i_cfg_we                 | i_cfg_idx, i_cfg_data
// Load requests are written straight into memory and taken back to back while idle. A solve runs
// the diagonal check, the start guess, the sweeps, then the results, one per row.
// The per-row cost is set by the matrix memory walk and the bit-serial divider.
// Reset is synchronous, active low; memory contents are not cleared.
// o_in_stall is high for the whole solve; the last result may wait in the output register.
`default_nettype none

module jacobi_iterative_solver_core #(
    parameter int MAX_ORDER = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire jis_pkg::t_in_req i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output jis_pkg::t_out_req     o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [15:0]      i_cfg_data
);

    localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int EW = (AW > 5) ? AW : 5;
    localparam int NW = jis_pkg::NUM_W;

    jis_pkg::t_state   r_state, n_state;
    logic [AW-1:0]     r_i, n_i, r_j, n_j, r_nm1, n_nm1, r_p1_j;
    logic [5:0]        r_cfg_order;
    logic [15:0]       r_cfg_tol, r_cfg_maxit;
    logic              r_bank, r_zero, r_dchk_v, r_p1_v, r_p2_v, r_rhs_pend;
    logic [1:0]        r_status;
    logic [15:0]       r_sweep;
    logic signed [15:0] r_diag;
    logic signed [31:0] r_old_i;
    logic signed [47:0] r_prod;
    logic signed [NW-1:0] r_acc;
    logic [32:0]       r_maxdiff;
    logic [31:0]       r_maxval;
    logic [47:0]       r_tolprod;
    logic              r_out_valid;
    jis_pkg::t_out_req r_out;

    logic              in_acc, out_acc, solve_acc, div_start, zero_now, converged;
    logic [EW-1:0]     row_ext, col_ext;
    logic              row_ok, col_ok, mat_we, rhs_we, sol_we;
    logic [2*AW-1:0]   mat_raddr;
    logic [AW:0]       sol_raddr, sol_waddr;
    logic signed [15:0] a_rdata, b_rdata;
    logic signed [31:0] x_rdata;
    logic signed [NW-1:0] rhs_scaled;
    logic signed [47:0] prod_nx;
    logic signed [32:0] diff, qx;
    logic [32:0]       absdiff;
    logic [31:0]       absval;
    jis_pkg::t_div_req div_req;
    jis_pkg::t_div_rsp div_rsp;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;
    assign solve_acc  = in_acc && (i_in.kind == jis_pkg::KIND_SOLVE);
    assign o_in_stall = (r_state != jis_pkg::ST_IDLE);

    assign row_ext = EW'(i_in.row);
    assign col_ext = EW'(i_in.col);
    assign row_ok  = 32'(i_in.row) < 32'(MAX_ORDER);
    assign col_ok  = 32'(i_in.col) < 32'(MAX_ORDER);
    assign mat_we  = in_acc && (i_in.kind == jis_pkg::KIND_MATRIX) && row_ok && col_ok;
    assign rhs_we  = in_acc && (i_in.kind == jis_pkg::KIND_RHS) && row_ok;

    always_comb begin
        if (r_state == jis_pkg::ST_DIAG || r_state == jis_pkg::ST_INIT_RD) begin
            mat_raddr = {r_i, r_i};
        end else begin
            mat_raddr = {r_i, r_j};
        end
        sol_raddr = (r_state == jis_pkg::ST_ROW_WALK) ? {r_bank, r_j} : {r_bank, r_i};
        sol_waddr = (r_state == jis_pkg::ST_ROW_WAIT) ? {!r_bank, r_i} : {r_bank, r_i};
        sol_we    = div_rsp.done && (r_state == jis_pkg::ST_ROW_WAIT ||
                                     r_state == jis_pkg::ST_INIT_WAIT);
    end

    jis_ram #(.DW(16), .AW(2 * AW)) u_mat (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr ({row_ext[AW-1:0], col_ext[AW-1:0]}),
        .i_wdata (i_in.value),
        .i_raddr (mat_raddr),
        .o_rdata (a_rdata)
    );

    jis_ram #(.DW(16), .AW(AW)) u_rhs (
        .i_clk   (i_clk),
        .i_we    (rhs_we),
        .i_waddr (row_ext[AW-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (r_i),
        .o_rdata (b_rdata)
    );

    jis_ram #(.DW(32), .AW(AW + 1)) u_sol (
        .i_clk   (i_clk),
        .i_we    (sol_we),
        .i_waddr (sol_waddr),
        .i_wdata (div_rsp.quot),
        .i_raddr (sol_raddr),
        .o_rdata (x_rdata)
    );

    jis_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        rhs_scaled    = NW'(b_rdata) <<< FRAC_BITS;
        prod_nx       = a_rdata * x_rdata;
        div_req.start = div_start;
        div_req.num   = (r_state == jis_pkg::ST_INIT_DIV) ? rhs_scaled : r_acc;
        div_req.den   = (r_state == jis_pkg::ST_INIT_DIV) ? a_rdata : r_diag;
        zero_now      = r_zero || (r_dchk_v && a_rdata == 16'sd0);
        converged     = (r_maxdiff == 33'd0) || ({r_maxdiff, 16'd0} < 49'(r_tolprod));
        diff          = 33'(div_rsp.quot) - 33'(r_old_i);
        absdiff       = diff[32] ? 33'(-diff) : 33'(diff);
        qx            = 33'(div_rsp.quot);
        absval        = qx[32] ? 32'(-qx) : 32'(qx);
        if (r_cfg_order == 6'd0) begin
            n_nm1 = '0;
        end else if (32'(r_cfg_order) > 32'(MAX_ORDER)) begin
            n_nm1 = AW'(MAX_ORDER - 1);
        end else begin
            n_nm1 = AW'(r_cfg_order - 6'd1);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        div_start = 1'b0;
        unique case (r_state)
            jis_pkg::ST_IDLE: begin
                if (solve_acc) begin
                    n_state = jis_pkg::ST_DIAG;
                    n_i     = '0;
                end
            end
            jis_pkg::ST_DIAG: begin
                if (r_i == r_nm1) begin
                    n_state = jis_pkg::ST_DIAG_END;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            jis_pkg::ST_DIAG_END: begin
                n_i     = '0;
                n_state = zero_now ? jis_pkg::ST_OUT_RD : jis_pkg::ST_INIT_RD;
            end
            jis_pkg::ST_INIT_RD: begin
                n_state = jis_pkg::ST_INIT_DIV;
            end
            jis_pkg::ST_INIT_DIV: begin
                div_start = 1'b1;
                n_state   = jis_pkg::ST_INIT_WAIT;
            end
            jis_pkg::ST_INIT_WAIT: begin
                if (div_rsp.done) begin
                    if (r_i == r_nm1) begin
                        n_i     = '0;
                        n_state = jis_pkg::ST_SWEEP_CHK;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = jis_pkg::ST_INIT_RD;
                    end
                end
            end
            jis_pkg::ST_SWEEP_CHK: begin
                n_i     = '0;
                n_state = (r_sweep >= r_cfg_maxit) ? jis_pkg::ST_OUT_RD
                                                   : jis_pkg::ST_ROW_INIT;
            end
            jis_pkg::ST_ROW_INIT: begin
                n_j     = '0;
                n_state = jis_pkg::ST_ROW_WALK;
            end
            jis_pkg::ST_ROW_WALK: begin
                if (r_j == r_nm1) begin
                    n_state = jis_pkg::ST_ROW_DRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            jis_pkg::ST_ROW_DRAIN: begin
                if (!r_p1_v && !r_p2_v) begin
                    n_state = jis_pkg::ST_ROW_DIV;
                end
            end
            jis_pkg::ST_ROW_DIV: begin
                div_start = 1'b1;
                n_state   = jis_pkg::ST_ROW_WAIT;
            end
            jis_pkg::ST_ROW_WAIT: begin
                if (div_rsp.done) begin
                    if (r_i == r_nm1) begin
                        n_i     = '0;
                        n_state = jis_pkg::ST_SWEEP_END;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = jis_pkg::ST_ROW_INIT;
                    end
                end
            end
            jis_pkg::ST_SWEEP_END: begin
                n_state = jis_pkg::ST_SWEEP_TEST;
            end
            jis_pkg::ST_SWEEP_TEST: begin
                n_i     = '0;
                n_state = converged ? jis_pkg::ST_OUT_RD : jis_pkg::ST_SWEEP_CHK;
            end
            jis_pkg::ST_OUT_RD: begin
                if (!r_out_valid || out_acc) begin
                    n_state = jis_pkg::ST_OUT_LD;
                end
            end
            jis_pkg::ST_OUT_LD: begin
                if (r_i == r_nm1) begin
                    n_state = jis_pkg::ST_IDLE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = jis_pkg::ST_OUT_RD;
                end
            end
            default: begin
                n_state = jis_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jis_pkg::ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_nm1       <= '0;
            r_cfg_order <= jis_pkg::CFG_ORDER_RST;
            r_cfg_tol   <= jis_pkg::CFG_TOL_RST;
            r_cfg_maxit <= jis_pkg::CFG_MAXIT_RST;
            r_bank      <= 1'b0;
            r_zero      <= 1'b0;
            r_status    <= jis_pkg::STATUS_CONV;
            r_sweep     <= '0;
            r_dchk_v    <= 1'b0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_rhs_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_i        <= n_i;
            r_j        <= n_j;
            r_dchk_v   <= (r_state == jis_pkg::ST_DIAG);
            r_p1_v     <= (r_state == jis_pkg::ST_ROW_WALK);
            r_p2_v     <= r_p1_v && (r_p1_j != r_i);
            r_rhs_pend <= (r_state == jis_pkg::ST_ROW_INIT);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    jis_pkg::CFG_ORDER: r_cfg_order <= i_cfg_data[5:0];
                    jis_pkg::CFG_TOL:   r_cfg_tol   <= i_cfg_data;
                    jis_pkg::CFG_MAXIT: r_cfg_maxit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (solve_acc) begin
                r_nm1   <= n_nm1;
                r_zero  <= 1'b0;
                r_sweep <= '0;
            end else if (r_dchk_v && a_rdata == 16'sd0) begin
                r_zero <= 1'b1;
            end
            if (r_state == jis_pkg::ST_DIAG_END && zero_now) begin
                r_status <= jis_pkg::STATUS_ZERO;
            end
            if (r_state == jis_pkg::ST_SWEEP_CHK && r_sweep >= r_cfg_maxit) begin
                r_status <= jis_pkg::STATUS_LIMIT;
            end
            if (r_state == jis_pkg::ST_SWEEP_TEST && converged) begin
                r_status <= jis_pkg::STATUS_CONV;
            end
            if (r_state == jis_pkg::ST_SWEEP_END) begin
                r_sweep <= r_sweep + 1'b1;
                r_bank  <= !r_bank;
            end
            if (r_state == jis_pkg::ST_OUT_LD) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_j <= r_j;
        r_prod <= prod_nx;
        if (r_p1_v && r_p1_j == r_i) begin
            r_diag  <= a_rdata;
            r_old_i <= x_rdata;
        end
        if (r_rhs_pend) begin
            r_acc <= rhs_scaled;
        end else if (r_p2_v) begin
            r_acc <= r_acc - NW'(r_prod);
        end
        if (r_state == jis_pkg::ST_SWEEP_CHK) begin
            r_maxdiff <= '0;
            r_maxval  <= '0;
        end else if (r_state == jis_pkg::ST_ROW_WAIT && div_rsp.done) begin
            if (absdiff > r_maxdiff) begin
                r_maxdiff <= absdiff;
            end
            if (absval > r_maxval) begin
                r_maxval <= absval;
            end
        end
        if (r_state == jis_pkg::ST_SWEEP_END) begin
            r_tolprod <= 48'(r_cfg_tol) * 48'(r_maxval);
        end
        if (r_state == jis_pkg::ST_OUT_LD) begin
            r_out.index      <= 5'(r_i);
            r_out.solution   <= (r_status == jis_pkg::STATUS_ZERO) ? 32'sd0 : x_rdata;
            r_out.last       <= (r_i == r_nm1);
            r_out.status     <= r_status;
            r_out.iterations <= r_sweep;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_row_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jis_pkg::ST_ROW_DIV) |-> (!r_p1_v && !r_p2_v && !r_rhs_pend))
        else $error("row divide started with products in flight");

    a_zero_diag_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == jis_pkg::STATUS_ZERO)
        |-> (o_out.iterations == 16'd0 && o_out.solution == 32'sd0))
        else $error("zero diagonal result carries data");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jis_pkg::ST_ROW_WALK) |-> (r_sweep < r_cfg_maxit))
        else $error("sweep beyond iteration limit");

endmodule

`default_nettype wire

// ===== hw/rtl/jis_ram.sv =====
`default_nettype none

module jis_ram #(
    parameter int DW = 16,
    parameter int AW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [DW-1:0]      o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/jis_div.sv =====
`default_nettype none

module jis_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire jis_pkg::t_div_req i_req,
    output jis_pkg::t_div_rsp      o_rsp
);

    localparam int NW    = jis_pkg::NUM_W;
    localparam int CNT_W = $clog2(NW);

    logic             r_busy;
    logic             r_fin;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_dvd;
    logic [16:0]      r_rem;
    logic [15:0]      r_ad;
    logic             r_neg;
    logic [31:0]      r_quot;

    logic [NW-1:0] an;
    logic [15:0]   ad;
    logic [NW-1:0] dvd0;
    logic [16:0]   rem_sh;
    logic          ge;
    logic [16:0]   rem_nx;
    logic [31:0]   quot_sat;

    always_comb begin
        an     = i_req.num[NW-1] ? (NW'(0) - NW'(i_req.num)) : NW'(i_req.num);
        ad     = i_req.den[15] ? (16'd0 - 16'(i_req.den)) : 16'(i_req.den);
        dvd0   = an + NW'(ad >> 1);
        rem_sh = {r_rem[15:0], r_dvd[NW-1]};
        ge     = rem_sh >= {1'b0, r_ad};
        rem_nx = ge ? (rem_sh - {1'b0, r_ad}) : rem_sh;
        if (r_neg) begin
            quot_sat = (r_dvd > NW'(64'h8000_0000)) ? 32'h8000_0000
                                                     : 32'(NW'(0) - r_dvd);
        end else begin
            quot_sat = (r_dvd > NW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r_dvd[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && !r_fin) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
                r_busy <= 1'b0;
                r_fin  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_dvd <= dvd0;
            r_rem <= '0;
            r_ad  <= ad;
            r_neg <= i_req.num[NW-1] ^ i_req.den[15];
        end else if (r_busy && !r_fin) begin
            r_dvd <= {r_dvd[NW-2:0], ge};
            r_rem <= rem_nx;
        end
        if (r_fin) begin
            r_quot <= quot_sat;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 1500000;
    localparam int ORD_MAX = 32;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    jis_pkg::t_in_req  i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    jis_pkg::t_out_req o_out;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    jacobi_iterative_solver_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // solver shadow state
    logic signed [15:0] a_mem [ORD_MAX][ORD_MAX];
    logic signed [15:0] b_mem [ORD_MAX];
    logic [5:0]  order_reg = jis_pkg::CFG_ORDER_RST;
    logic [15:0] tol_reg   = jis_pkg::CFG_TOL_RST;
    logic [15:0] maxit_reg = jis_pkg::CFG_MAXIT_RST;

    jis_pkg::t_in_req  request_q [$];
    jis_pkg::t_out_req solution_q [$];
    int errors = 0;
    int items = 0;
    int idle_cycles = 0;

    function automatic logic signed [31:0] round_div(longint num, longint den);
        longint an, ad, q;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (an + ad / 2) / ad;
        if ((num < 0) != (den < 0)) q = -q;
        if (q > 64'sd2147483647) return 32'sh7fffffff;
        if (q < -64'sd2147483648) return 32'sh80000000;
        return q[31:0];
    endfunction

    task automatic solve_system();
        int n, sweeps;
        logic [1:0] st;
        longint xo [ORD_MAX];
        longint xn [ORD_MAX];
        longint acc, diff, mag, maxdiff, maxval;
        jis_pkg::t_out_req r;
        n = (order_reg < 1) ? 1 : (order_reg > ORD_MAX) ? ORD_MAX : order_reg;
        sweeps = 0;
        st = jis_pkg::STATUS_CONV;
        for (int i = 0; i < n; i++)
            if (a_mem[i][i] == 0) st = jis_pkg::STATUS_ZERO;
        if (st == jis_pkg::STATUS_ZERO) begin
            for (int i = 0; i < n; i++) xn[i] = 0;
        end else begin
            for (int i = 0; i < n; i++)
                xn[i] = round_div(longint'(b_mem[i]) * 65536, longint'(a_mem[i][i]));
            forever begin
                if (sweeps >= maxit_reg) begin
                    st = jis_pkg::STATUS_LIMIT;
                    break;
                end
                for (int i = 0; i < n; i++) xo[i] = xn[i];
                maxdiff = 0;
                maxval = 0;
                for (int i = 0; i < n; i++) begin
                    acc = longint'(b_mem[i]) * 65536;
                    for (int j = 0; j < n; j++)
                        if (j != i) acc -= longint'(a_mem[i][j]) * xo[j];
                    xn[i] = round_div(acc, longint'(a_mem[i][i]));
                    diff = xn[i] - xo[i];
                    if (diff < 0) diff = -diff;
                    if (diff > maxdiff) maxdiff = diff;
                    mag = (xn[i] < 0) ? -xn[i] : xn[i];
                    if (mag > maxval) maxval = mag;
                end
                sweeps++;
                if (maxdiff == 0 || maxdiff * 65536 < longint'(tol_reg) * maxval) begin
                    st = jis_pkg::STATUS_CONV;
                    break;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            r.index = i[4:0];
            r.solution = xn[i][31:0];
            r.last = (i == n - 1);
            r.status = st;
            r.iterations = sweeps[15:0];
            solution_q.push_back(r);
        end
    endtask

    task automatic apply_request(jis_pkg::t_in_req q);
        case (q.kind)
            jis_pkg::KIND_MATRIX: a_mem[q.row][q.col] = q.value;
            jis_pkg::KIND_RHS:    b_mem[q.row] = q.value;
            jis_pkg::KIND_SOLVE:  solve_system();
            default: ;
        endcase
    endtask

    // driver
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) apply_request(i_in);
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    i_in <= request_q.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor, receiver stall pattern, watchdog
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (solution_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: index %0d solution %0d", o_out.index,
                                 o_out.solution);
                end else begin
                    jis_pkg::t_out_req e;
                    e = solution_q.pop_front();
                    if (o_out.index !== e.index || o_out.solution !== e.solution ||
                        o_out.last !== e.last || o_out.status !== e.status ||
                        o_out.iterations !== e.iterations) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp idx %0d x %0d last %0d st %0d it %0d,",
                                      " got idx %0d x %0d last %0d st %0d it %0d"},
                                     e.index, e.solution, e.last, e.status, e.iterations,
                                     o_out.index, o_out.solution, o_out.last, o_out.status,
                                     o_out.iterations);
                    end
                end
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 80);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= mode_left[1];
            endcase
        end
    end

    task automatic push_req(logic [1:0] k, int r, int c, int v);
        jis_pkg::t_in_req q;
        q.kind = k;
        q.row = r[4:0];
        q.col = c[4:0];
        q.value = v[15:0];
        request_q.push_back(q);
        items++;
    endtask

    task automatic set_config(int ord, int tol, int maxit);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= jis_pkg::CFG_ORDER;
        i_cfg_data <= ord[15:0];
        @(posedge i_clk);
        i_cfg_idx <= jis_pkg::CFG_TOL;
        i_cfg_data <= tol[15:0];
        @(posedge i_clk);
        i_cfg_idx <= jis_pkg::CFG_MAXIT;
        i_cfg_data <= maxit[15:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        order_reg = ord[5:0];
        tol_reg = tol[15:0];
        maxit_reg = maxit[15:0];
    endtask

    task automatic wait_idle();
        while (request_q.size() > 0 || i_in_valid || solution_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // style: 0 diagonally dominant, 1 unconstrained, 2 diagonal only
    task automatic load_system(int n, int style);
        int v;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (i == j)
                    v = (style == 1) ? $urandom_range(0, 65535) - 32768 :
                        n * 100 + $urandom_range(1, 20000);
                else
                    v = (style == 2) ? 0 : (style == 1) ? $urandom_range(0, 65535) - 32768 :
                        $urandom_range(0, 200) - 100;
                if (i == j && style != 1 && $urandom_range(0, 1)) v = -v;
                push_req(jis_pkg::KIND_MATRIX, i, j, v);
            end
            push_req(jis_pkg::KIND_RHS, i, $urandom_range(0, 31),
                     $urandom_range(0, 65535) - 32768);
        end
    endtask

    initial begin
        int n, tol, maxit, style;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: order 4
        load_system(4, 0);
        push_req(jis_pkg::KIND_RHS, 0, 0, 32767);
        push_req(jis_pkg::KIND_RHS, 1, 31, -32768);
        push_req(jis_pkg::KIND_MATRIX, 3, 3, 32767);
        push_req(jis_pkg::KIND_SOLVE, 0, 0, 0);
        push_req(KIND_UNUSED, 31, 31, -1);
        push_req(jis_pkg::KIND_MATRIX, 2, 2, 0);
        push_req(jis_pkg::KIND_SOLVE, 31, 31, -1);
        push_req(jis_pkg::KIND_MATRIX, 2, 2, -32768);
        push_req(jis_pkg::KIND_MATRIX, 0, 0, -32768);
        wait_idle();

        // order 0 acts as 1, zero limit gives the start guess
        set_config(0, 65535, 0);
        push_req(jis_pkg::KIND_SOLVE, 0, 0, 0);
        wait_idle();

        set_config(3, 98, 65535);
        load_system(3, 2);
        push_req(jis_pkg::KIND_SOLVE, 0, 0, 0);
        wait_idle();

        set_config(2, 0, 40);
        load_system(2, 1);
        push_req(jis_pkg::KIND_SOLVE, 0, 0, 0);
        wait_idle();

        // order above range acts as the maximum; zero limit reads only diagonal and rhs
        set_config(63, 2000, 0);
        for (int i = 0; i < ORD_MAX; i++) begin
            push_req(jis_pkg::KIND_MATRIX, i, i,
                     $urandom_range(0, 1) ? -3300 - i : 3300 + i);
            push_req(jis_pkg::KIND_RHS, i, 0, $urandom_range(0, 65535) - 32768);
        end
        push_req(jis_pkg::KIND_SOLVE, 0, 0, 0);
        wait_idle();
        set_config(32, 65535, 0);
        push_req(jis_pkg::KIND_MATRIX, 31, 31, 0);
        push_req(jis_pkg::KIND_SOLVE, 0, 0, 0);
        wait_idle();

        while (items < 500) begin
            n = $urandom_range(1, 6);
            style = ($urandom_range(0, 4) == 0) ? 1 : ($urandom_range(0, 5) == 0) ? 2 : 0;
            case ($urandom_range(0, 3))
                0: tol = 0;
                1: tol = 98;
                2: tol = 65535;
                default: tol = $urandom_range(0, 65535);
            endcase
            maxit = (style == 1 || tol == 0) ? $urandom_range(1, 30) : $urandom_range(1, 200);
            set_config(n, tol, maxit);
            load_system(n, style);
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 3)) begin
                    if ($urandom_range(0, 3) == 0)
                        push_req(KIND_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                                 $urandom_range(0, 65535));
                    else if ($urandom_range(0, 1))
                        push_req(jis_pkg::KIND_RHS, $urandom_range(0, n - 1),
                                 $urandom_range(0, 31), $urandom_range(0, 65535) - 32768);
                    else
                        push_req(jis_pkg::KIND_MATRIX, $urandom_range(0, n - 1),
                                 $urandom_range(0, n - 1), $urandom_range(0, 400) - 200);
                end
                push_req(jis_pkg::KIND_SOLVE, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 65535));
            end
            wait_idle();
        end

        repeat (40) @(posedge i_clk);
        if (errors == 0 && solution_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/jis_pkg.sv
hw/rtl/jis_ram.sv
hw/rtl/jis_div.sv
hw/rtl/jacobi_iterative_solver_core.sv
tb/testbench.sv
